>>> hdl/csv_tok_pkg.sv
// csv_tok_pkg: types and constants shared by the csv byte tokenizer
// parse states, token kinds, special byte codes and the result group struct
// no dependencies
package csv_tok_pkg;

  typedef enum logic [2:0] {
    PS_START,
    PS_EF,
    PS_EFBB,
    PS_FIELD,
    PS_QUOTE,
    PS_QEND,
    PS_CR
  } parse_state_t;

  typedef enum logic [2:0] {
    K_DATA,
    K_FEND,
    K_REND,
    K_EOI,
    K_QERR
  } kind_t;

  localparam logic [7:0] BYTE_BOM0  = 8'hEF;
  localparam logic [7:0] BYTE_BOM1  = 8'hBB;
  localparam logic [7:0] BYTE_BOM2  = 8'hBF;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_COMMA = 8'h2C;

  localparam int MAX_RESULTS = 3;

  // results caused by one input item; position fields are shared by all of them
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][2:0]  kind;
    logic [MAX_RESULTS-1:0][7:0]  data;
    logic [7:0]                   field_index;
    logic                         in_header;
    logic [31:0]                  row;
    logic [31:0]                  col;
  } group_t;

endpackage

>>> hdl/csv_tok_if.sv
// csv_tok_in_if and csv_tok_out_if: valid/ready channels of the csv tokenizer
// input carries raw bytes, output carries tokens with position info
// no dependencies
interface csv_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface csv_tok_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  field_index;
  logic        in_header;
  logic [31:0] error_row;
  logic [31:0] error_col;
  logic        last;

  modport source (output valid, kind, data_byte, field_index, in_header,
                  error_row, error_col, last, input ready);
  modport sink (input valid, kind, data_byte, field_index, in_header,
                error_row, error_col, last, output ready);
endinterface

>>> hdl/csv_tok_parse.sv
// csv_tok_parse: parser state registers and the single-step token decision
// builds the result group for one registered input item
// depends on csv_tok_pkg
module csv_tok_parse #(
  parameter int MAX_FIELDS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  output csv_tok_pkg::group_t grp
);
  import csv_tok_pkg::*;

  localparam int         CapInt    = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;
  localparam logic [7:0] FIELD_CAP = 8'(CapInt);

  parse_state_t ps, ps_next, st;
  logic         header_pending, header_pending_next;
  logic [7:0]   field_count, field_count_next;
  logic [31:0]  row_counter, row_counter_next;
  logic [31:0]  col_counter, col_counter_next;

  logic                        flush_en;
  logic [1:0]                  n;
  logic [MAX_RESULTS-1:0][2:0] kinds;
  logic [MAX_RESULTS-1:0][7:0] datas;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps             <= PS_START;
      header_pending <= 1'b1;
      field_count    <= '0;
      row_counter    <= '0;
      col_counter    <= '0;
    end else if (step) begin
      ps             <= ps_next;
      header_pending <= header_pending_next;
      field_count    <= field_count_next;
      row_counter    <= row_counter_next;
      col_counter    <= col_counter_next;
    end
  end

  always_comb begin
    n                   = '0;
    kinds               = '0;
    datas               = '0;
    header_pending_next = header_pending;
    field_count_next    = field_count;
    row_counter_next    = row_counter;
    col_counter_next    = col_counter;

    // bom bytes and the lf of a cr lf pair do not release held bytes
    if (end_of_input) begin
      flush_en = 1'b1;
    end else if (in_byte == BYTE_LF) begin
      flush_en = (ps != PS_CR);
    end else if (in_byte == BYTE_CR || in_byte == BYTE_QUOTE || in_byte == BYTE_COMMA) begin
      flush_en = 1'b1;
    end else if (header_pending && in_byte == BYTE_BOM0 && ps == PS_START) begin
      flush_en = 1'b0;
    end else if (header_pending && in_byte == BYTE_BOM1 && ps == PS_EF) begin
      flush_en = 1'b0;
    end else if (header_pending && in_byte == BYTE_BOM2 && ps == PS_EFBB) begin
      flush_en = 1'b0;
    end else begin
      flush_en = 1'b1;
    end

    st = ps;
    if (flush_en) begin
      case (ps)
        PS_EF: begin
          kinds[n] = K_DATA;
          datas[n] = BYTE_BOM0;
          n        = n + 2'd1;
          st       = PS_FIELD;
        end
        PS_EFBB: begin
          kinds[n] = K_DATA;
          datas[n] = BYTE_BOM0;
          n        = n + 2'd1;
          kinds[n] = K_DATA;
          datas[n] = BYTE_BOM1;
          n        = n + 2'd1;
          st       = PS_FIELD;
        end
        PS_CR: begin
          kinds[n] = K_DATA;
          datas[n] = BYTE_CR;
          n        = n + 2'd1;
          st       = PS_FIELD;
        end
        default: ;
      endcase
    end

    if (end_of_input) begin
      if (st == PS_START) begin
        kinds[n] = K_EOI;
        n        = n + 2'd1;
      end else if (st == PS_QUOTE) begin
        kinds[n]         = K_QERR;
        n                = n + 2'd1;
        st               = PS_START;
        field_count_next = '0;
      end else begin
        kinds[n]            = K_REND;
        n                   = n + 2'd1;
        st                  = PS_START;
        field_count_next    = '0;
        header_pending_next = 1'b0;
      end
    end else if (in_byte == BYTE_LF) begin
      if (ps == PS_CR) begin
        st = PS_FIELD;
      end
      if (st == PS_QUOTE) begin
        kinds[n] = K_DATA;
        datas[n] = BYTE_LF;
        n        = n + 2'd1;
      end else begin
        kinds[n]            = K_REND;
        n                   = n + 2'd1;
        st                  = PS_START;
        field_count_next    = '0;
        header_pending_next = 1'b0;
      end
      row_counter_next = row_counter + 32'd1;
      col_counter_next = '0;
    end else begin
      if (in_byte == BYTE_CR) begin
        if (st == PS_QUOTE) begin
          kinds[n] = K_DATA;
          datas[n] = BYTE_CR;
          n        = n + 2'd1;
        end else begin
          st = PS_CR;
        end
      end else if (in_byte == BYTE_QUOTE) begin
        if (st == PS_QUOTE) begin
          st = PS_QEND;
        end else if (st == PS_QEND) begin
          kinds[n] = K_DATA;
          datas[n] = BYTE_QUOTE;
          n        = n + 2'd1;
          st       = PS_QUOTE;
        end else begin
          st = PS_QUOTE;
        end
      end else if (in_byte == BYTE_COMMA) begin
        if (st == PS_QUOTE) begin
          kinds[n] = K_DATA;
          datas[n] = BYTE_COMMA;
          n        = n + 2'd1;
        end else begin
          kinds[n] = K_FEND;
          n        = n + 2'd1;
          if (field_count < FIELD_CAP) begin
            field_count_next = field_count + 8'd1;
          end
          st = PS_FIELD;
        end
      end else if (!flush_en) begin
        // byte order mark progress
        case (ps)
          PS_START: st = PS_EF;
          PS_EF:    st = PS_EFBB;
          default:  st = PS_FIELD;
        endcase
      end else begin
        kinds[n] = K_DATA;
        datas[n] = in_byte;
        n        = n + 2'd1;
        if (st != PS_QUOTE) begin
          st = PS_FIELD;
        end
      end
      col_counter_next = col_counter + 32'd1;
    end

    ps_next = st;
  end

  assign grp.cnt         = n;
  assign grp.kind        = kinds;
  assign grp.data        = datas;
  assign grp.field_index = field_count;
  assign grp.in_header   = header_pending;
  assign grp.row         = row_counter;
  assign grp.col         = col_counter;

endmodule

>>> hdl/csv_tok_emit.sv
// csv_tok_emit: result group register and output serializer
// hands the results of one item out one transfer at a time
// depends on csv_tok_pkg and csv_tok_out_if
module csv_tok_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  csv_tok_pkg::group_t grp_in,
  output logic                free,
  csv_tok_out_if.source       tokens
);
  import csv_tok_pkg::*;

  group_t     grp;
  logic [1:0] cnt;
  logic [1:0] pos;
  logic       is_last;
  logic       xfer;

  assign is_last = (pos == cnt - 2'd1);
  assign xfer    = tokens.valid && tokens.ready;
  assign free    = (cnt == 2'd0) || (xfer && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
    end else if (load) begin
      cnt <= grp_in.cnt;
      pos <= '0;
    end else if (xfer) begin
      if (is_last) begin
        cnt <= '0;
        pos <= '0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  assign tokens.valid       = (cnt != 2'd0);
  assign tokens.kind        = grp.kind[pos];
  assign tokens.data_byte   = grp.data[pos];
  assign tokens.field_index = grp.field_index;
  assign tokens.in_header   = grp.in_header;
  assign tokens.error_row   = grp.row;
  assign tokens.error_col   = grp.col;
  assign tokens.last        = is_last;

endmodule

>>> hdl/csv_byte_tokenizer.sv
// csv_byte_tokenizer: streaming csv tokenizer, one byte or end marker per input transfer
// depends on csv_tok_pkg, csv_tok_if, csv_tok_parse and csv_tok_emit
//
// Splits a byte stream into data bytes, field ends and record ends (comma, LF, CR LF,
// double-quote quoting with doubled quotes, header byte order mark stripped) and reports
// end of input or an unterminated quote, each token carrying row and column counters.
// An input byte is registered, decided combinationally and its results (zero to three)
// land in a result register; while the output does not stall and every item yields at
// most one token, a new byte is taken every cycle. An item that yields more tokens holds
// the input back until its last token is taken, as the result register hands out one token
// per transfer; a token is offered once its byte has gone through both registers.
module csv_byte_tokenizer #(
  parameter int MAX_FIELDS = 256
) (
  input logic          clk,
  input logic          rst,
  csv_tok_in_if.sink   stream,
  csv_tok_out_if.source tokens
);
  import csv_tok_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       step;
  logic       free;
  group_t     grp;

  assign step         = in_valid && free;
  assign stream.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      in_byte <= stream.in_byte;
      in_eoi  <= stream.end_of_input;
    end
  end

  csv_tok_parse #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (in_byte),
    .end_of_input (in_eoi),
    .grp          (grp)
  );

  csv_tok_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .grp_in (grp),
    .free   (free),
    .tokens (tokens)
  );

endmodule

>>> hdl/csv_tok_checker.sv
// csv_tok_checker: port-level checks on the csv tokenizer output stream
// bound to csv_byte_tokenizer; depends on csv_tok_pkg
module csv_tok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [7:0]  data_byte,
  input logic [7:0]  field_index,
  input logic [31:0] error_row,
  input logic [31:0] error_col,
  input logic        last
);
  import csv_tok_pkg::*;

  // stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte) && $stable(last))
    else $error("token changed while stalled");

  // tokens of one item follow without a gap and share position info
  a_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && $stable(error_row) &&
      $stable(error_col) && $stable(field_index))
    else $error("token group broken");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_DATA |-> data_byte == 8'd0)
    else $error("non-data token carries a byte");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == K_EOI || kind == K_QERR) |-> last)
    else $error("end or error token not alone");

endmodule

bind csv_byte_tokenizer csv_tok_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .kind        (tokens.kind),
  .data_byte   (tokens.data_byte),
  .field_index (tokens.field_index),
  .error_row   (tokens.error_row),
  .error_col   (tokens.error_col),
  .last        (tokens.last)
);
